[hw/rtl/wled_pkg.sv]
// Shared constants, codes and types of the windowed local extremum detector.
`default_nettype none
package wled_pkg;

  localparam int MAX_HALF_WINDOW = 16;
  localparam int WIN_DEPTH       = 2 * MAX_HALF_WINDOW - 1;
  localparam int RAD_W           = $clog2(MAX_HALF_WINDOW + 1);
  localparam int IDX_W           = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int CNT_W           = $clog2(WIN_DEPTH + 1);

  localparam int DATA_W    = 32;
  localparam int HW_W      = 5;
  localparam int SKIP_W    = 32;
  localparam int CAP_W     = 16;
  localparam int KEN_W     = 3;
  localparam int REP_W     = 17;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSIENT_SKIP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_CAP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND_ENABLE    = 2'd3;

  localparam logic [HW_W-1:0]   RST_HALF_WINDOW    = 5'd5;
  localparam logic [SKIP_W-1:0] RST_TRANSIENT_SKIP = 32'd20000;
  localparam logic [CAP_W-1:0]  RST_REPORT_CAP     = 16'd100;
  localparam logic [KEN_W-1:0]  RST_KIND_ENABLE    = 3'd1;

  localparam logic [KIND_W-1:0] KIND_MAX  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MIN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLAT = 2'd2;

  typedef struct packed {
    logic [HW_W-1:0]   half_window;
    logic [SKIP_W-1:0] transient_skip;
    logic [CAP_W-1:0]  report_cap;
    logic [KEN_W-1:0]  kind_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] value;
    logic [DATA_W-1:0]        index;
    logic [KIND_W-1:0]        kind;
    logic                     last;
  } report_t;

endpackage
`default_nettype wire

[hw/rtl/windowed_local_extremum_detector.sv]
// Top level: configuration registers, front end and report queue.
// Each sample passes through load, a window scan with one compare per cycle, issue of
// its reports (at most 3) and the queue; a sample whose center is not evaluated skips
// scan and issue. A new sample is taken only when the last is done, and issue waits while
// the queue is full; the single window comparator serves every center.
// Queue holds 4 reports. Reset clears counters and control, sets default config; no clearing pass.
`default_nettype none
module windowed_local_extremum_detector import wled_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [DATA_W-1:0]        cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [DATA_W-1:0] position_i,
  input  wire logic signed [DATA_W-1:0] sample_value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      point_position_o,
  output logic signed [DATA_W-1:0]      point_value_o,
  output logic [DATA_W-1:0]             point_index_o,
  output logic [KIND_W-1:0]             point_kind_o,
  output logic                          last_of_run_o
);

  cfg_t    cfg_q;
  logic    push;
  report_t push_data;
  logic    q_full;
  report_t out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_window    <= RST_HALF_WINDOW;
      cfg_q.transient_skip <= RST_TRANSIENT_SKIP;
      cfg_q.report_cap     <= RST_REPORT_CAP;
      cfg_q.kind_enable    <= RST_KIND_ENABLE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HALF_WINDOW:    cfg_q.half_window    <= cfg_data_i[HW_W-1:0];
        CFG_TRANSIENT_SKIP: cfg_q.transient_skip <= cfg_data_i[SKIP_W-1:0];
        CFG_REPORT_CAP:     cfg_q.report_cap     <= cfg_data_i[CAP_W-1:0];
        CFG_KIND_ENABLE:    cfg_q.kind_enable    <= cfg_data_i[KEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wled_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .position_i     (position_i),
    .sample_value_i (sample_value_i),
    .push_o         (push),
    .push_data_o    (push_data),
    .q_full_i       (q_full)
  );

  wled_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign point_position_o = out_data.position;
  assign point_value_o    = out_data.value;
  assign point_index_o    = out_data.index;
  assign point_kind_o     = out_data.kind;
  assign last_of_run_o    = out_data.last;

endmodule
`default_nettype wire

[hw/rtl/wled_front.sv]
// Front end: sample window, center scan, classification and report issue.
`default_nettype none
module wled_front import wled_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cfg_t                     cfg_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [DATA_W-1:0] position_i,
  input  wire logic signed [DATA_W-1:0] sample_value_i,
  output logic                          push_o,
  output report_t                       push_data_o,
  input  wire logic                     q_full_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_q, state_d;

  logic [DATA_W-1:0] val_win_q [WIN_DEPTH];
  logic [DATA_W-1:0] pos_win_q [WIN_DEPTH];

  logic [DATA_W-1:0] samples_q, samples_d;
  logic [DATA_W-1:0] cidx_q, cidx_d;
  logic              ok_q, ok_d;
  logic [DATA_W-1:0] cval_q, cval_d;
  logic [DATA_W-1:0] cpos_q, cpos_d;
  logic [IDX_W-1:0]  j_q, j_d;
  logic [CNT_W-1:0]  below_q, below_d, above_q, above_d, equal_q, equal_d;
  logic [2:0]        hits_q, hits_d;
  logic [REP_W-1:0]  reports_q, reports_d;

  logic [RAD_W-1:0]  r;
  logic [CNT_W-1:0]  span, span_m1;
  logic [IDX_W-1:0]  ctr_idx, rd_addr;
  logic [DATA_W-1:0] rd_val, rd_pos;
  logic              accept, eval;
  logic [2:0]        hits_rest;

  always_comb begin
    if (cfg_i.half_window == '0) begin
      r = RAD_W'(1);
    end else if (int'(cfg_i.half_window) > MAX_HALF_WINDOW) begin
      r = RAD_W'(MAX_HALF_WINDOW);
    end else begin
      r = RAD_W'(cfg_i.half_window);
    end
  end

  assign span    = CNT_W'({CNT_W'(r), 1'b0} - 1'b1);
  assign span_m1 = span - 1'b1;
  assign ctr_idx = IDX_W'(r - 1'b1);

  assign rd_addr = (state_q == ST_LOAD) ? ctr_idx : j_q;
  assign rd_val  = val_win_q[rd_addr];
  assign rd_pos  = pos_win_q[rd_addr];

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign eval = ok_q && (cidx_q >= DATA_W'(span_m1)) && (cidx_q >= cfg_i.transient_skip)
                && (reports_q < REP_W'(cfg_i.report_cap));

  assign hits_rest = hits_q & (hits_q - 3'd1);

  always_comb begin
    push_data_o.position = cpos_q;
    push_data_o.value    = cval_q;
    push_data_o.index    = cidx_q;
    push_data_o.last     = (hits_rest == '0);
    if (hits_q[0]) begin
      push_data_o.kind = KIND_MAX;
    end else if (hits_q[1]) begin
      push_data_o.kind = KIND_MIN;
    end else begin
      push_data_o.kind = KIND_FLAT;
    end
  end

  always_comb begin
    state_d   = state_q;
    samples_d = samples_q;
    cidx_d    = cidx_q;
    ok_d      = ok_q;
    cval_d    = cval_q;
    cpos_d    = cpos_q;
    j_d       = j_q;
    below_d   = below_q;
    above_d   = above_q;
    equal_d   = equal_q;
    hits_d    = hits_q;
    reports_d = reports_q;
    push_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ok_d    = 1'b0;
          cidx_d  = samples_q - DATA_W'(ctr_idx);
          if (samples_q != '1) begin
            samples_d = samples_q + 1'b1;
            ok_d      = (samples_q >= DATA_W'(ctr_idx));
          end
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cval_d  = rd_val;
        cpos_d  = rd_pos;
        j_d     = '0;
        below_d = '0;
        above_d = '0;
        equal_d = '0;
        state_d = eval ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if ($signed(cval_q) > $signed(rd_val)) begin
          below_d = below_q + 1'b1;
        end else if ($signed(cval_q) < $signed(rd_val)) begin
          above_d = above_q + 1'b1;
        end else begin
          equal_d = equal_q + 1'b1;
        end
        j_d = j_q + 1'b1;
        if (CNT_W'(j_q) == span_m1) begin
          hits_d[0] = (below_d == span_m1) && cfg_i.kind_enable[0];
          hits_d[1] = (above_d == span_m1) && cfg_i.kind_enable[1];
          hits_d[2] = (equal_d == span)    && cfg_i.kind_enable[2];
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (hits_q == '0) begin
          state_d = ST_IDLE;
        end else if (!q_full_i) begin
          push_o    = 1'b1;
          reports_d = reports_q + 1'b1;
          hits_d    = hits_rest;
          if (hits_rest == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      samples_q <= '0;
      reports_q <= '0;
      ok_q      <= 1'b0;
      hits_q    <= '0;
      j_q       <= '0;
    end else begin
      state_q   <= state_d;
      samples_q <= samples_d;
      reports_q <= reports_d;
      ok_q      <= ok_d;
      hits_q    <= hits_d;
      j_q       <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cidx_q  <= cidx_d;
    cval_q  <= cval_d;
    cpos_q  <= cpos_d;
    below_q <= below_d;
    above_q <= above_d;
    equal_q <= equal_d;
  end

  // advance the window, newest sample at entry zero
  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_win_q[0] <= sample_value_i;
      pos_win_q[0] <= position_i;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        val_win_q[i] <= val_win_q[i-1];
        pos_win_q[i] <= pos_win_q[i-1];
      end
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("report issued into a full queue");

  a_report_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> reports_q == $past(reports_q) + 1'b1)
    else $error("report count out of step with issued reports");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CNT_W'(j_q) <= span_m1))
    else $error("scan index ran past the window");

endmodule
`default_nettype wire

[hw/rtl/wled_queue.sv]
// Back end: report queue that drives the result channel.
`default_nettype none
module wled_queue import wled_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire report_t push_data_i,
  output logic         full_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output report_t      out_data_o
);

  report_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               pop;

  assign full_o      = (count_q == QCNT_W'(QDEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue occupancy beyond depth");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> count_q == $past(count_q) - 1'b1)
    else $error("queue occupancy not reduced on drain");

endmodule
`default_nettype wire

[test/tb_windowed_local_extremum_detector.sv]
// Self-checking testbench of the windowed local extremum detector with a built-in peak predictor.
module tb_windowed_local_extremum_detector;
  import wled_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] value;
  } sample_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i      = '0;
  logic [DATA_W-1:0]        cfg_data_i     = '0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] position_i     = '0;
  logic signed [DATA_W-1:0] sample_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic signed [DATA_W-1:0] point_position_o;
  logic signed [DATA_W-1:0] point_value_o;
  logic [DATA_W-1:0]        point_index_o;
  logic [KIND_W-1:0]        point_kind_o;
  logic                     last_of_run_o;

  windowed_local_extremum_detector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .position_i       (position_i),
    .sample_value_i   (sample_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .point_position_o (point_position_o),
    .point_value_o    (point_value_o),
    .point_index_o    (point_index_o),
    .point_kind_o     (point_kind_o),
    .last_of_run_o    (last_of_run_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [HW_W-1:0]          radius_reg   = RST_HALF_WINDOW;
  logic [SKIP_W-1:0]        skip_reg     = RST_TRANSIENT_SKIP;
  logic [CAP_W-1:0]         cap_reg      = RST_REPORT_CAP;
  logic [KEN_W-1:0]         kind_mask    = RST_KIND_ENABLE;
  logic signed [DATA_W-1:0] value_hist [WIN_DEPTH];
  logic signed [DATA_W-1:0] pos_hist   [WIN_DEPTH];
  logic [DATA_W-1:0]        sample_count = '0;
  logic [REP_W-1:0]         report_total = '0;

  sample_t sample_queue[$];
  report_t expected_peaks[$];

  int gap_pct         = 12;
  int stall_pct       = 12;
  int failures        = 0;
  int samples_sent    = 0;
  int reports_checked = 0;
  int settings_used   = 0;
  int random_items    = 0;

  initial begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      value_hist[i] = '0;
      pos_hist[i]   = '0;
    end
  end

  function automatic int eff_radius(input logic [HW_W-1:0] hw);
    if (hw == 0) return 1;
    if (hw > MAX_HALF_WINDOW) return MAX_HALF_WINDOW;
    return hw;
  endfunction

  task automatic predict_peaks(input logic signed [DATA_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val);
    int r;
    int i;
    int below;
    int above;
    int equal;
    int made;
    logic [DATA_W-1:0] n;
    logic [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] centre;
    report_t rep;
    r = eff_radius(radius_reg);
    n = sample_count;
    for (i = WIN_DEPTH - 1; i > 0; i--) begin
      value_hist[i] = value_hist[i-1];
      pos_hist[i]   = pos_hist[i-1];
    end
    value_hist[0] = val;
    pos_hist[0]   = pos;
    if (n == '1) return;
    sample_count = n + 1;
    if (n < r - 1) return;
    c = n - (r - 1);
    if (c < 2 * r - 2 || c < skip_reg || report_total >= cap_reg) return;
    centre = value_hist[r-1];
    below = 0;
    above = 0;
    equal = 0;
    for (i = 0; i < 2 * r - 1; i++) begin
      if (centre > value_hist[i]) below++;
      else if (centre < value_hist[i]) above++;
      else equal++;
    end
    rep.position = pos_hist[r-1];
    rep.value    = centre;
    rep.index    = c;
    rep.last     = 1'b0;
    made = 0;
    if (below == 2 * r - 2 && kind_mask[0]) begin
      rep.kind = KIND_MAX;
      expected_peaks.push_back(rep);
      report_total++;
      made++;
    end
    if (above == 2 * r - 2 && kind_mask[1]) begin
      rep.kind = KIND_MIN;
      expected_peaks.push_back(rep);
      report_total++;
      made++;
    end
    if (equal == 2 * r - 1 && kind_mask[2]) begin
      rep.kind = KIND_FLAT;
      expected_peaks.push_back(rep);
      report_total++;
      made++;
    end
    if (made > 0) expected_peaks[expected_peaks.size()-1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_samples
    sample_t beat;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        predict_peaks(position_i, sample_value_i);
        samples_sent++;
      end
      if (sample_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
        beat = sample_queue.pop_front();
        in_valid_i     <= 1'b1;
        position_i     <= beat.position;
        sample_value_i <= beat.value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_reports
    report_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        reports_checked++;
        if (expected_peaks.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected report: pos %h value %h index %0d kind %0d last %b",
                     point_position_o, point_value_o, point_index_o, point_kind_o,
                     last_of_run_o);
        end else begin
          want = expected_peaks.pop_front();
          if (point_position_o !== want.position || point_value_o !== want.value ||
              point_index_o !== want.index || point_kind_o !== want.kind ||
              last_of_run_o !== want.last) begin
            failures++;
            if (failures <= 10) begin
              $display("report mismatch (exp/got): pos %h/%h value %h/%h",
                       want.position, point_position_o, want.value, point_value_o);
              $display("  index %0d/%0d kind %0d/%0d last %b/%b",
                       want.index, point_index_o, want.kind, point_kind_o,
                       want.last, last_of_run_o);
            end
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_HALF_WINDOW:    radius_reg = data[HW_W-1:0];
      CFG_TRANSIENT_SKIP: skip_reg   = data;
      CFG_REPORT_CAP:     cap_reg    = data[CAP_W-1:0];
      CFG_KIND_ENABLE:    kind_mask  = data[KEN_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic [HW_W-1:0] hw, input logic [SKIP_W-1:0] skip,
                           input logic [CAP_W-1:0] cap, input logic [KEN_W-1:0] kinds);
    write_reg(CFG_HALF_WINDOW, ($urandom() & 32'hFFFF_FFE0) | hw);
    write_reg(CFG_TRANSIENT_SKIP, skip);
    write_reg(CFG_REPORT_CAP, ($urandom() & 32'hFFFF_0000) | cap);
    write_reg(CFG_KIND_ENABLE, ($urandom() & 32'hFFFF_FFF8) | kinds);
    settings_used++;
    @(negedge clk_i);
  endtask

  task automatic queue_sample(input logic [DATA_W-1:0] pos, input logic [DATA_W-1:0] val);
    sample_t s;
    s.position = pos;
    s.value    = val;
    sample_queue.push_back(s);
  endtask

  // wait for the last report, then for any item still in the window scan
  task automatic settle();
    while (sample_queue.size() != 0 || in_valid_i || expected_peaks.size() != 0)
      @(negedge clk_i);
    repeat (2 * MAX_HALF_WINDOW + 8) @(negedge clk_i);
  endtask

  task automatic random_phase(input int count);
    int r;
    int span;
    int k;
    int p;
    int shape;
    int style;
    int offset;
    bit broken;
    logic signed [DATA_W-1:0] base;
    logic [DATA_W-1:0] val;
    r      = eff_radius(radius_reg);
    span   = 2 * r - 1;
    style  = $urandom_range(9);
    shape  = 0;
    broken = 1'b0;
    base   = '0;
    for (k = 0; k < count; k++) begin
      p = k % span;
      if (style < 2) begin
        val = $urandom();
      end else if (style < 4) begin
        val = $urandom_range(2) - 1;
      end else begin
        if (p == 0) begin
          shape  = $urandom_range(2);
          base   = $signed($urandom()) >>> 1;
          broken = ($urandom_range(7) == 0);
        end
        offset = $urandom_range(1, 1 << 20);
        if (p == span / 2 || shape == 2 || (broken && p == 0)) val = base;
        else if (shape == 0) val = base - offset;
        else val = base + offset;
      end
      queue_sample($urandom(), val);
      random_items++;
    end
  endtask

  initial begin : stimulus
    logic [HW_W-1:0]   hw;
    logic [SKIP_W-1:0] skip;
    logic [CAP_W-1:0]  cap;
    logic [KEN_W-1:0]  kinds;
    int phase;
    int count;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // defaults: window not yet full
    queue_sample(32'h0000_0001, 32'h7FFF_FFFF);
    queue_sample(32'hFFFF_FFFF, 32'h8000_0000);
    settle();

    // radius two, every kind: minimum, flat, maximum at value extremes
    configure(5'd2, 32'd0, 16'hFFFF, 3'd7);
    queue_sample(32'h8000_0000, 32'h0000_0000);
    queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_sample(32'h0000_0000, 32'h8000_0000);
    queue_sample(32'hFFFF_FFFF, 32'h0000_0005);
    queue_sample(32'h5555_5555, 32'h0000_0005);
    queue_sample(32'hAAAA_AAAA, 32'h0000_0005);
    queue_sample(32'h1234_5678, 32'h7FFF_FFFF);
    queue_sample(32'hEDCB_A987, 32'h8000_0000);
    queue_sample(32'h0000_0000, 32'h0000_0000);
    settle();

    // zero radius acts as one: each center is maximum, minimum and flat
    configure(5'd0, 32'd0, 16'hFFFF, 3'd7);
    queue_sample($urandom(), $urandom());
    queue_sample($urandom(), 32'h8000_0000);
    queue_sample($urandom(), 32'h7FFF_FFFF);
    settle();

    // cap one above the count: a single center overshoots, then silence
    configure(5'd1, 32'd0, CAP_W'(report_total + 1), 3'd7);
    queue_sample($urandom(), $urandom());
    queue_sample($urandom(), $urandom());
    settle();

    // oversize radius, skip and cap at their blocking extremes
    configure(5'd31, 32'hFFFF_FFFF, 16'd0, 3'd0);
    queue_sample($urandom(), $urandom());
    queue_sample($urandom(), $urandom());
    queue_sample($urandom(), $urandom());
    settle();

    phase = 0;
    while (random_items < 150) begin
      case ($urandom_range(9))
        0:       hw = 5'd0;
        1, 2:    hw = 5'd1;
        3:       hw = 5'd2;
        4:       hw = 5'd3;
        5:       hw = 5'd4;
        6:       hw = 5'd6;
        7:       hw = 5'd8;
        8:       hw = 5'd16;
        default: hw = $urandom_range(17, 31);
      endcase
      skip  = ($urandom_range(3) == 0) ? sample_count + $urandom_range(2, 10) : 32'd0;
      cap   = ($urandom_range(4) == 0) ? CAP_W'(report_total + $urandom_range(2)) : 16'hFFFF;
      kinds = ($urandom_range(7) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
      configure(hw, skip, cap, kinds);
      if (phase == 2) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      count = eff_radius(hw) >= 8 ? 2 * (2 * eff_radius(hw) - 1) : $urandom_range(12, 24);
      if (count > 150 - random_items) count = 150 - random_items;
      random_phase(count);
      settle();
      gap_pct   = 12;
      stall_pct = 12;
      phase++;
    end

    $display("Ran %0d samples through %0d register settings; %0d reports compared, %0d bad.",
             samples_sent, settings_used, reports_checked, failures);
    if (failures == 0 && expected_peaks.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Run stalled with %0d reports outstanding.", expected_peaks.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
